@@ hdl/cau_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIV0 = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

endpackage
`default_nettype wire

@@ hdl/complex_arith_unit.sv @@
// Complex ALU on signed fixed-point parts (Q8.8 by default): add, subtract,
// multiply, divide. s_tdata carries opcode, a_re, a_im, b_re, b_im from bit 0 up;
// m_tdata carries res_re, res_im, status. One beat is taken every cycle while the
// output is not stalled. The pipe holds four front stages, one restoring divider stage
// per quotient bit (2*WORD_BITS + 2 + FRAC_BITS of them) and the output register;
// every opcode goes through the same pipe so results leave in order. A stalled
// output freezes the whole pipe.
`timescale 1ns / 1ps
`default_nettype none
module complex_arith_unit #(
	parameter int FRAC_BITS = 8,
	parameter int WORD_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// opcode, a_re, a_im, b_re, b_im, zero pad
	input  wire logic [((2 + 4 * WORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// res_re, res_im, status, zero pad
	output logic [((2 + 2 * WORD_BITS + 7) / 8) * 8 - 1:0] m_tdata
);
	import cau_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int PW = 2 * W + 2;          // magnitude of sum of products
	localparam int NW = PW + FRAC_BITS;     // dividend bits
	localparam int DW = 2 * W + 1;          // divisor bits
	localparam int QN = NW;                 // divider stages
	localparam int SW = ((2 + 2 * W + 7) / 8) * 8;
	localparam logic [PW-1:0] LIM = PW'(1) << (W - 1);

	logic adv;
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage 1: register operands
	logic        v_s1;
	op_t         op_s1;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= op_t'(s_tdata[1:0]);
			ar_s1 <= s_tdata[2 +: W];
			ai_s1 <= s_tdata[2 + W +: W];
			br_s1 <= s_tdata[2 + 2 * W +: W];
			bi_s1 <= s_tdata[2 + 3 * W +: W];
		end
	end

	// stage 2: the four cross products, squares and add/sub sums
	logic        v_s2;
	op_t         op_s2;
	logic signed [2*W-1:0] pac_s2, pbd_s2, pad_s2, pbc_s2, pcc_s2, pdd_s2;
	logic signed [W:0] sr_s2, si_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2  <= op_s1;
			pac_s2 <= ar_s1 * br_s1;
			pbd_s2 <= ai_s1 * bi_s1;
			pad_s2 <= ar_s1 * bi_s1;
			pbc_s2 <= ai_s1 * br_s1;
			pcc_s2 <= br_s1 * br_s1;
			pdd_s2 <= bi_s1 * bi_s1;
			sr_s2  <= (op_s1 == OP_SUB) ? (W+1)'(ar_s1) - (W+1)'(br_s1)
			                            : (W+1)'(ar_s1) + (W+1)'(br_s1);
			si_s2  <= (op_s1 == OP_SUB) ? (W+1)'(ai_s1) - (W+1)'(bi_s1)
			                            : (W+1)'(ai_s1) + (W+1)'(bi_s1);
		end
	end

	// stage 3: combine into signed sums, divisor
	logic signed [PW-1:0] nre_c, nim_c;
	always_comb begin
		case (op_s2)
			OP_MUL: begin
				nre_c = PW'(pac_s2) - PW'(pbd_s2);
				nim_c = PW'(pad_s2) + PW'(pbc_s2);
			end
			OP_DIV: begin
				nre_c = PW'(pac_s2) + PW'(pbd_s2);
				nim_c = PW'(pbc_s2) - PW'(pad_s2);
			end
			default: begin
				nre_c = PW'(sr_s2);
				nim_c = PW'(si_s2);
			end
		endcase
	end

	logic        v_s3;
	op_t         op_s3;
	logic signed [PW-1:0] nre_s3, nim_s3;
	logic [DW-1:0] den_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3  <= op_s2;
			nre_s3 <= nre_c;
			nim_s3 <= nim_c;
			den_s3 <= DW'(unsigned'(pcc_s2)) + DW'(unsigned'(pdd_s2));
		end
	end

	// stage 4: sign and magnitude; multiply results are shifted down, divide dividends up
	logic [PW-1:0] are_c, aim_c;
	assign are_c = nre_s3[PW-1] ? PW'(-nre_s3) : PW'(nre_s3);
	assign aim_c = nim_s3[PW-1] ? PW'(-nim_s3) : PW'(nim_s3);

	logic        v_s4;
	op_t         op_s4;
	logic        sre_s4, sim_s4;
	logic [NW-1:0] mre_s4, mim_s4;
	logic [DW-1:0] den_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s4  <= op_s3;
			den_s4 <= den_s3;
			sre_s4 <= nre_s3[PW-1];
			sim_s4 <= nim_s3[PW-1];
			case (op_s3)
				OP_DIV: begin
					mre_s4 <= NW'(are_c) << FRAC_BITS;
					mim_s4 <= NW'(aim_c) << FRAC_BITS;
				end
				OP_MUL: begin
					// arithmetic shift = floor
					mre_s4 <= NW'(nre_s3[PW-1] ? (are_c + PW'((1 << FRAC_BITS) - 1)) >> FRAC_BITS
					                           : are_c >> FRAC_BITS);
					mim_s4 <= NW'(nim_s3[PW-1] ? (aim_c + PW'((1 << FRAC_BITS) - 1)) >> FRAC_BITS
					                           : aim_c >> FRAC_BITS);
				end
				default: begin
					mre_s4 <= NW'(are_c);
					mim_s4 <= NW'(aim_c);
				end
			endcase
		end
	end

	// divider stages: one restoring step per stage, two lanes share the divisor
	logic          dv_q  [QN+1];
	op_t           dop_q [QN+1];
	logic          dsr_q [QN+1];
	logic          dsi_q [QN+1];
	logic [NW-1:0] dnr_q [QN+1];  // dividend shifting out, quotient shifting in
	logic [NW-1:0] dni_q [QN+1];
	logic [DW:0]   drr_q [QN+1];
	logic [DW:0]   dri_q [QN+1];
	logic [DW-1:0] dd_q  [QN+1];

	always_comb begin
		dv_q[0]  = v_s4;
		dop_q[0] = op_s4;
		dsr_q[0] = sre_s4;
		dsi_q[0] = sim_s4;
		dnr_q[0] = mre_s4;
		dni_q[0] = mim_s4;
		drr_q[0] = '0;
		dri_q[0] = '0;
		dd_q[0]  = den_s4;
	end

	for (genvar k = 0; k < QN; k++) begin : g_div
		logic [DW:0] tr, ti;
		logic        qr, qi;
		always_comb begin
			tr = {drr_q[k][DW-1:0], dnr_q[k][NW-1]};
			ti = {dri_q[k][DW-1:0], dni_q[k][NW-1]};
			qr = (dop_q[k] == OP_DIV) && (tr >= {1'b0, dd_q[k]});
			qi = (dop_q[k] == OP_DIV) && (ti >= {1'b0, dd_q[k]});
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_q[k+1] <= 1'b0;
			else if (adv) dv_q[k+1] <= dv_q[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dop_q[k+1] <= dop_q[k];
				dsr_q[k+1] <= dsr_q[k];
				dsi_q[k+1] <= dsi_q[k];
				dd_q[k+1]  <= dd_q[k];
				if (dop_q[k] == OP_DIV) begin
					drr_q[k+1] <= qr ? tr - {1'b0, dd_q[k]} : tr;
					dri_q[k+1] <= qi ? ti - {1'b0, dd_q[k]} : ti;
					dnr_q[k+1] <= {dnr_q[k][NW-2:0], qr};
					dni_q[k+1] <= {dni_q[k][NW-2:0], qi};
				end else begin
					drr_q[k+1] <= drr_q[k];
					dri_q[k+1] <= dri_q[k];
					dnr_q[k+1] <= dnr_q[k];
					dni_q[k+1] <= dni_q[k];
				end
			end
		end
	end

	// output stage: saturate, zero-divisor, status
	logic [NW-1:0] fr, fi;
	logic nr, ni, satr, sati, dz;
	logic [W-1:0] rr, ri;
	assign fr = dnr_q[QN];
	assign fi = dni_q[QN];
	assign nr = dsr_q[QN] && (fr != '0);
	assign ni = dsi_q[QN] && (fi != '0);
	assign dz = (dop_q[QN] == OP_DIV) && (dd_q[QN] == '0);
	always_comb begin
		satr = nr ? (fr > NW'(LIM)) : (fr > NW'(LIM - 1'b1));
		sati = ni ? (fi > NW'(LIM)) : (fi > NW'(LIM - 1'b1));
		if (satr) rr = nr ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		else rr = nr ? W'(-fr) : W'(fr);
		if (sati) ri = ni ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		else ri = ni ? W'(-fi) : W'(fi);
	end

	status_t st;
	assign st = dz ? ST_DIV0 : ((satr || sati) ? ST_SAT : ST_OK);

	logic [SW-1:0] out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (adv) m_tvalid <= dv_q[QN];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= SW'({st, (dz ? {W{1'b0}} : ri), (dz ? {W{1'b0}} : rr)});
		end
	end
	assign m_tdata = out_q;

endmodule
`default_nettype wire
